### sv/fdxb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdxb_pkg
// Shared types, constants and the CRC column function for the FDX-B frame
// builder.
// ----------------------------------------------------------------------------
`default_nettype none

package fdxb_pkg;

  localparam int FRAME_BITS     = 128;
  localparam int DATA_BITS      = 104;
  localparam int CRC_DATA_BITS  = 64;
  localparam int PREAMBLE_ZEROS = 10;
  localparam int FIRST_GROUP    = 11;
  localparam int GROUP_STRIDE   = 9;
  localparam int WORD_BITS      = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [1:0]  WORD_LAST = 2'd3;

  // data bit positions of the fields
  localparam int NAT_POS  = 0;
  localparam int CTY_POS  = 38;
  localparam int EXTF_POS = 48;
  localparam int ANIM_POS = 63;
  localparam int CRC_POS  = 64;
  localparam int EXT_POS  = 80;

  typedef struct packed {
    logic [37:0] national_code;
    logic [9:0]  country_code;
    logic        animal_flag;
    logic        extended_flag;
    logic [23:0] extended_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  // frame bit 0 is the first one on the air
  typedef logic [0:FRAME_BITS-1] frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // crc contribution of one set data bit (crc is linear with zero init)
  function automatic logic [15:0] crc_col(input int k);
    logic [15:0] c;
    logic [7:0]  b;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      b = (i == (k >> 3)) ? (8'h80 >> (k & 7)) : 8'h00;
      c = c ^ {8'h00, b};
      for (int j = 0; j < 8; j++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/fdxb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdxb_front
// Takes identity transfers into a stage register, lays out the data bits,
// computes the CRC and builds the 128-bit frame for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fdxb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fdxb_pkg::in_item_t in_data,
  input  wire fdxb_pkg::q_stat_t q_stat,
  output logic                   push,
  output fdxb_pkg::frame_t       push_frame
);

  logic               stage_v_r, stage_v_nxt;
  fdxb_pkg::in_item_t stage_r;
  logic               take;

  logic [fdxb_pkg::DATA_BITS-1:0]     d;
  logic [fdxb_pkg::CRC_DATA_BITS-1:0] d_lo;
  logic [15:0]                        crc;
  logic [15:0]                        term [fdxb_pkg::CRC_DATA_BITS];

  // handshake
  assign in_stall = stage_v_r && q_stat.full;
  assign take     = in_valid && !in_stall;
  assign push     = stage_v_r && !q_stat.full;

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (take) begin
      stage_v_nxt = 1'b1;
    end else if (push) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_r <= in_data;
    end
  end

  // first eight groups: identity, flags, reserved zeros
  always_comb begin
    d_lo = '0;
    d_lo[fdxb_pkg::NAT_POS +: 38] = stage_r.national_code;
    d_lo[fdxb_pkg::CTY_POS +: 10] = stage_r.country_code;
    d_lo[fdxb_pkg::EXTF_POS]      = stage_r.extended_flag;
    d_lo[fdxb_pkg::ANIM_POS]      = stage_r.animal_flag;
  end

  // crc as an xor tree over constant columns
  for (genvar k = 0; k < fdxb_pkg::CRC_DATA_BITS; k++) begin : g_col
    localparam logic [15:0] COL = fdxb_pkg::crc_col(k);
    assign term[k] = d_lo[k] ? COL : 16'h0000;
  end

  always_comb begin
    crc = '0;
    for (int k = 0; k < fdxb_pkg::CRC_DATA_BITS; k++) begin
      crc = crc ^ term[k];
    end
  end

  // full data word
  always_comb begin
    d = '0;
    d[fdxb_pkg::CRC_DATA_BITS-1:0] = d_lo;
    d[fdxb_pkg::CRC_POS +: 16]     = crc;
    d[fdxb_pkg::EXT_POS +: 24]     = stage_r.extended_data;
  end

  // frame layout: preamble, groups with one markers
  always_comb begin
    push_frame = '1;
    for (int f = 0; f < fdxb_pkg::PREAMBLE_ZEROS; f++) begin
      push_frame[f] = 1'b0;
    end
    for (int k = 0; k < fdxb_pkg::DATA_BITS; k++) begin
      push_frame[fdxb_pkg::FIRST_GROUP + fdxb_pkg::GROUP_STRIDE * (k >> 3) + (k & 7)] = d[k];
    end
  end

endmodule

`default_nettype wire

### sv/fdxb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdxb_queue
// Short frame queue between the encoder front and the word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fdxb_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire fdxb_pkg::frame_t push_frame,
  input  wire logic             pop,
  output fdxb_pkg::frame_t      head,
  output fdxb_pkg::q_stat_t     q_stat
);

  fdxb_pkg::frame_t              mem_r [fdxb_pkg::QUEUE_DEPTH];
  logic [fdxb_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [fdxb_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [fdxb_pkg::QCNT_W-1:0]   count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == fdxb_pkg::QCNT_W'(fdxb_pkg::QUEUE_DEPTH));
  assign head         = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == fdxb_pkg::QPTR_W'(fdxb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == fdxb_pkg::QPTR_W'(fdxb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

`default_nettype wire

### sv/fdxb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdxb_back
// Word sequencer: cuts the head frame into four 32-bit words and holds each
// in the output register until its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module fdxb_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fdxb_pkg::frame_t  head,
  input  wire fdxb_pkg::q_stat_t q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fdxb_pkg::out_item_t    out_data
);

  logic                out_valid_r, out_valid_nxt;
  fdxb_pkg::out_item_t out_data_r, out_data_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                slot_free;
  logic                load;

  assign slot_free = !out_valid_r || !out_stall;
  assign load      = slot_free && !q_stat.empty;
  assign pop       = load && (idx_r == fdxb_pkg::WORD_LAST);

  // next word and output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt           = 1'b1;
      idx_nxt                 = idx_r + 1'b1;
      out_data_nxt.frame_word = head[{idx_r, 5'b00000} +: fdxb_pkg::WORD_BITS];
      out_data_nxt.word_index = idx_r;
      out_data_nxt.last_word  = (idx_r == fdxb_pkg::WORD_LAST);
    end else if (slot_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### sv/fdxb_frame_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdxb_frame_builder_core
// FDX-B transmit frame encoder: one tag identity in, four 32-bit frame words
// out, first transmitted bit at the MSB of word 0.
// Path: an identity passes the stage register, a queue entry and the output
// register. Throughput: one word per cycle while out_stall is low, set by the
// output word sequencer; the two-frame queue lets the input run ahead.
// Reset: synchronous, active low; clears the stage, queue and sequencer
// control state, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fdxb_frame_builder_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire fdxb_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fdxb_pkg::out_item_t      out_data
);

  logic              push;
  logic              pop;
  fdxb_pkg::frame_t  push_frame;
  fdxb_pkg::frame_t  head;
  fdxb_pkg::q_stat_t q_stat;

  // encoder front
  fdxb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_frame (push_frame)
  );

  // frame queue
  fdxb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // word sequencer
  fdxb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // words of one frame follow in order once a non-final word transfers
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_word |=>
      out_valid && (out_data.word_index == $past(out_data.word_index) + 2'd1))
    else $error("frame words out of order");

  // last flag marks exactly the final word
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == fdxb_pkg::WORD_LAST)))
    else $error("last_word does not match word_index");

  // no push into a full queue, no pop from an empty one
  a_queue_guard: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full) && !(pop && q_stat.empty))
    else $error("queue overflow or underflow");

endmodule

`default_nettype wire

### test/fdxb_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdxb_frame_checker
// Watches both channels of the FDX-B frame builder. Every identity transfer
// is encoded here into its four expected frame words. Every word transfer is
// compared field by field against the oldest expected word. The failure
// count and the number of words still owed go back to the testbench top.
// ----------------------------------------------------------------------------

module fdxb_frame_checker
  import fdxb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        words_owed
);

  out_item_t expected_words[$];
  int        mismatches = 0;

  assign fail_count = mismatches;

  // encode one identity into the 128-bit air frame, bit 0 sent first
  function automatic logic [0:FRAME_BITS-1] encode_frame(input in_item_t id);
    logic [DATA_BITS-1:0]  dbits;
    logic [0:FRAME_BITS-1] fr;
    logic [15:0]           crc;
    logic [7:0]            octet;
    dbits = '0;
    dbits[NAT_POS +: 38]  = id.national_code;
    dbits[CTY_POS +: 10]  = id.country_code;
    dbits[EXTF_POS]       = id.extended_flag;
    dbits[ANIM_POS]       = id.animal_flag;
    // kermit crc over the first eight groups, first-sent bit as byte msb
    crc = '0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) octet[7-j] = dbits[8*i+j];
      crc = crc ^ {8'h00, octet};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    dbits[CRC_POS +: 16] = crc;
    dbits[EXT_POS +: 24] = id.extended_data;
    // preamble, then groups of eight with a one marker after each
    fr = '1;
    fr[0:PREAMBLE_ZEROS-1] = '0;
    for (int k = 0; k < DATA_BITS; k++) begin
      fr[FIRST_GROUP + GROUP_STRIDE*(k/8) + (k%8)] = dbits[k];
    end
    return fr;
  endfunction

  // predict on identity transfers, compare on word transfers
  always @(posedge clk) begin
    logic [0:FRAME_BITS-1] fr;
    out_item_t             exp_w;
    if (!rst_n) begin
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        fr = encode_frame(in_data);
        for (int w = 0; w < 4; w++) begin
          exp_w.frame_word = fr[WORD_BITS*w +: WORD_BITS];
          exp_w.word_index = w[1:0];
          exp_w.last_word  = (w[1:0] == WORD_LAST);
          expected_words.push_back(exp_w);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word transfer, got word %h index %0d last %0b",
                   $time, out_data.frame_word, out_data.word_index, out_data.last_word);
          mismatches++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data.frame_word !== exp_w.frame_word) begin
            $display("%0t: frame_word mismatch, expected %h actual %h",
                     $time, exp_w.frame_word, out_data.frame_word);
            mismatches++;
          end
          if (out_data.word_index !== exp_w.word_index) begin
            $display("%0t: word_index mismatch, expected %0d actual %0d",
                     $time, exp_w.word_index, out_data.word_index);
            mismatches++;
          end
          if (out_data.last_word !== exp_w.last_word) begin
            $display("%0t: last_word mismatch, expected %0b actual %0b",
                     $time, exp_w.last_word, out_data.last_word);
            mismatches++;
          end
        end
      end
    end
    words_owed <= expected_words.size();
  end

endmodule

### test/fdxb_frame_builder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdxb_frame_builder_core_tb
// Drives tag identities into the FDX-B frame builder: a directed set of
// field extremes and flag combinations, then random identities under random
// sender gaps and receiver stalls, one long receiver hold-off that backs the
// block up, and a final stretch at full rate. The checker does the compare.
// ----------------------------------------------------------------------------

module fdxb_frame_builder_core_tb;
  import fdxb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 200;
  localparam int FINAL_ITEMS  = 40;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int words_owed;
  int cycle_cnt = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  fdxb_frame_builder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fdxb_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_item_t make_identity(input logic [37:0] nat, input logic [9:0] cty,
                                             input logic anim, input logic extf,
                                             input logic [23:0] ext);
    in_item_t id;
    id.national_code = nat;
    id.country_code  = cty;
    id.animal_flag   = anim;
    id.extended_flag = extf;
    id.extended_data = ext;
    return id;
  endfunction

  // random identity, with field extremes mixed in now and then
  function automatic in_item_t random_identity();
    in_item_t    id;
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    id.national_code = wide[37:0];
    id.country_code  = 10'($urandom_range(0, 1023));
    id.animal_flag   = 1'($urandom_range(0, 1));
    id.extended_flag = 1'($urandom_range(0, 1));
    id.extended_data = 24'($urandom_range(0, 24'hFFFFFF));
    case ($urandom_range(0, 15))
      0: id.national_code = '0;
      1: id.national_code = '1;
      2: id.country_code  = '0;
      3: id.country_code  = '1;
      4: id.extended_data = '0;
      5: id.extended_data = '1;
      default: ;
    endcase
    return id;
  endfunction

  // offer one identity and wait for its transfer
  task automatic offer_identity(input in_item_t id);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= id;
    do @(posedge clk); while (in_stall);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus and verdict
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, flag combinations, walking and alternating bits
    offer_identity(make_identity('0, '0, 1'b0, 1'b0, '0));
    offer_identity(make_identity('1, '1, 1'b1, 1'b1, '1));
    offer_identity(make_identity('1, '0, 1'b0, 1'b0, '0));
    offer_identity(make_identity('0, '1, 1'b0, 1'b0, '0));
    offer_identity(make_identity('0, '0, 1'b1, 1'b0, '0));
    offer_identity(make_identity('0, '0, 1'b0, 1'b1, '0));
    offer_identity(make_identity('0, '0, 1'b0, 1'b0, '1));
    offer_identity(make_identity(38'h1, 10'h001, 1'b0, 1'b0, 24'h000001));
    offer_identity(make_identity(38'h20_0000_0000, 10'h200, 1'b1, 1'b1, 24'h800000));
    offer_identity(make_identity(38'h2A_AAAA_AAAA, 10'h2AA, 1'b1, 1'b0, 24'hAAAAAA));
    offer_identity(make_identity(38'h15_5555_5555, 10'h155, 1'b0, 1'b1, 24'h555555));
    offer_identity(make_identity(38'h00_0000_0080, 10'h3E7, 1'b1, 1'b0, 24'h00FF00));
    offer_identity(make_identity(38'h3F_0000_00FF, 10'h0F0, 1'b0, 1'b1, 24'hFF00FF));
    offer_identity(make_identity('1, '1, 1'b0, 1'b0, '0));
    offer_identity(make_identity('0, '0, 1'b1, 1'b1, '1));
    tx_idle_en = 1'b1;
    for (int i = 0; i < 5; i++) offer_identity(random_identity());

    // random identities, idling switched on and off in stretches
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 16 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      if (i == HOLD_AT) hold_req = 1'b1;
      offer_identity(random_identity());
    end

    // full rate to the end
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < FINAL_ITEMS; i++) offer_identity(random_identity());
    in_valid <= 1'b0;

    do @(posedge clk); while (words_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && words_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### fdxb_frame_builder_core.f
sv/fdxb_pkg.sv
sv/fdxb_front.sv
sv/fdxb_queue.sv
sv/fdxb_back.sv
sv/fdxb_frame_builder_core.sv
test/fdxb_frame_checker.sv
test/fdxb_frame_builder_core_tb.sv
